/* rtl/sacache_pkg.sv */
// Shared types and constants of the set-associative cache tag and LRU timing block.
// Holds op codes, state encoding, configuration indexes and fixed field widths.
// Depends on nothing; every other file takes it in.
package sacache_pkg;

    // Fixed widths of the channel fields.
    localparam int ADDR_W     = 32;
    localparam int HIT_LAT_W  = 8;
    localparam int MISS_PEN_W = 10;
    localparam int LAT_W      = 11;
    localparam int CNT_W      = 64;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // A dirty eviction adds half the miss penalty again.
    localparam int HALF_DIVISOR = 2;

    // Configuration register indexes and their reset values.
    localparam logic [CFG_IDX_W-1:0]  CFG_HIT_LAT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0]  CFG_MISS_PEN = CFG_IDX_W'(1);
    localparam logic [HIT_LAT_W-1:0]  HIT_LAT_RST  = HIT_LAT_W'(1);
    localparam logic [MISS_PEN_W-1:0] MISS_PEN_RST = MISS_PEN_W'(100);

    // Request operation codes.
    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_INVAL = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    // Control sequencer states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    // Status of one set lookup, passed from the lookup logic to the top level.
    typedef struct packed {
        logic hit;
        logic dirty_evict;
    } lookup_status_t;

endpackage

/* rtl/sacache_req_if.sv */
// Request channel of the cache tag block: valid/ready handshake with op and address.
// Depends on sacache_pkg for the op code type.
interface sacache_req_if;
    logic                              valid;
    logic                              ready;
    sacache_pkg::op_t                  op;
    logic [sacache_pkg::ADDR_W-1:0]    addr;

    modport source (output valid, output op, output addr, input ready);
    modport sink   (input valid, input op, input addr, output ready);
endinterface

/* rtl/sacache_rsp_if.sv */
// Response channel of the cache tag block: valid/ready handshake with the access outcome.
// Depends on sacache_pkg for field widths.
interface sacache_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              hit;
    logic                              dirty_evict;
    logic [sacache_pkg::LAT_W-1:0]     latency;
    logic [sacache_pkg::CNT_W-1:0]     total_accesses;
    logic [sacache_pkg::CNT_W-1:0]     total_hits;

    modport source (output valid, output hit, output dirty_evict, output latency,
                    output total_accesses, output total_hits, input ready);
    modport sink   (input valid, input hit, input dirty_evict, input latency,
                    input total_accesses, input total_hits, output ready);
endinterface

/* rtl/sacache_cfg_if.sv */
// Configuration write channel of the cache tag block: valid/ready with index and data.
// Depends on sacache_pkg for field widths.
interface sacache_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [sacache_pkg::CFG_IDX_W-1:0]   index;
    logic [sacache_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/sacache_lookup.sv */
// Set lookup logic: parallel tag compare, victim choice and counter-based LRU update.
// Purely combinational over one set row; depends on sacache_pkg for the status struct.
module sacache_lookup #(
    parameter int WAY_COUNT = 4,
    parameter int TAG_W     = 20,
    parameter int AGE_W     = 2
) (
    input  logic [WAY_COUNT*TAG_W-1:0]   tag_row,
    input  logic [WAY_COUNT-1:0]         valid_row,
    input  logic [WAY_COUNT-1:0]         dirty_row,
    input  logic [WAY_COUNT*AGE_W-1:0]   age_row,
    input  logic [TAG_W-1:0]             tag,
    input  logic                         is_write,
    output sacache_pkg::lookup_status_t  status,
    output logic [WAY_COUNT*TAG_W-1:0]   tag_row_new,
    output logic [WAY_COUNT-1:0]         valid_row_new,
    output logic [WAY_COUNT-1:0]         dirty_row_new,
    output logic [WAY_COUNT*AGE_W-1:0]   age_row_new
);
    import sacache_pkg::*;

    localparam int WAY_W = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;

    logic [WAY_COUNT-1:0] match;
    logic                 hit;
    logic [WAY_W-1:0]     hit_way;
    logic                 any_invalid;
    logic [WAY_W-1:0]     invalid_way;
    logic [WAY_W-1:0]     oldest_way;
    logic [AGE_W-1:0]     top_age;
    logic [WAY_W-1:0]     way;
    logic [WAY_COUNT-1:0] sel;
    logic [WAY_COUNT-1:0] wr_mask;
    logic [AGE_W-1:0]     old_age;

    // Compare every valid way against the tag and find the lowest matching way.
    always_comb
    begin
        hit_way     = '0;
        invalid_way = '0;
        any_invalid = 1'b0;
        for (int i = WAY_COUNT - 1; i >= 0; i--)
        begin
            match[i] = valid_row[i] && (tag_row[i*TAG_W +: TAG_W] == tag);
            if (match[i])
            begin
                hit_way = WAY_W'(i);
            end
            if (!valid_row[i])
            begin
                invalid_way = WAY_W'(i);
                any_invalid = 1'b1;
            end
        end
        hit = |match;
    end

    // The lowest-numbered way holding the largest counter is the oldest.
    always_comb
    begin
        top_age    = '0;
        oldest_way = '0;
        for (int i = 0; i < WAY_COUNT; i++)
        begin
            if (age_row[i*AGE_W +: AGE_W] > top_age)
            begin
                top_age    = age_row[i*AGE_W +: AGE_W];
                oldest_way = WAY_W'(i);
            end
        end
    end

    // Choose the touched way: the hit way, else the first invalid way, else the oldest.
    always_comb
    begin
        if (hit)
        begin
            way = hit_way;
        end
        else if (any_invalid)
        begin
            way = invalid_way;
        end
        else
        begin
            way = oldest_way;
        end
        sel = '0;
        for (int i = 0; i < WAY_COUNT; i++)
        begin
            sel[i] = (way == WAY_W'(i));
        end
        wr_mask = is_write ? sel : '0;
    end

    // Fill on a miss, set dirty on a write and age the set.
    always_comb
    begin
        old_age = '0;
        for (int i = 0; i < WAY_COUNT; i++)
        begin
            if (sel[i])
            begin
                old_age = age_row[i*AGE_W +: AGE_W];
            end
        end

        valid_row_new = valid_row | sel;
        dirty_row_new = hit ? (dirty_row | wr_mask) : ((dirty_row & ~sel) | wr_mask);

        tag_row_new = tag_row;
        for (int i = 0; i < WAY_COUNT; i++)
        begin
            if (sel[i] && !hit)
            begin
                tag_row_new[i*TAG_W +: TAG_W] = tag;
            end
        end

        // Ways younger than the touched one age by one; the touched way becomes newest.
        for (int i = 0; i < WAY_COUNT; i++)
        begin
            if (sel[i])
            begin
                age_row_new[i*AGE_W +: AGE_W] = '0;
            end
            else if (valid_row_new[i] && (age_row[i*AGE_W +: AGE_W] < old_age))
            begin
                age_row_new[i*AGE_W +: AGE_W] = age_row[i*AGE_W +: AGE_W] + AGE_W'(1);
            end
            else
            begin
                age_row_new[i*AGE_W +: AGE_W] = age_row[i*AGE_W +: AGE_W];
            end
        end

        status.hit         = hit;
        status.dirty_evict = !hit && (|(valid_row & dirty_row & sel));
    end

endmodule

/* rtl/set_assoc_cache_tag_lru_timing_top.sv */
// Top level of the set-associative cache tag and LRU timing block.
// Depends on sacache_pkg, the three channel interfaces and sacache_lookup.
//
// Usage:
//   req carries one transaction per access: op (read, write, invalidate) and a byte
//   address. rsp returns one transaction per request: hit, dirty_evict, the reported
//   latency and the running access and hit totals. cfg writes index 0 (hit latency) and
//   index 1 (miss penalty); it is always ready and must only be used while idle.
//   A read or write reads the set from the tag and state memories at the accepting
//   edge; in the lookup state it is then compared, updated and written back. Each
//   access is a single read-modify-write of one set row, and the next request is taken
//   only once the sequencer is idle again. After an invalidate loads its response, the
//   whole state memory is swept one set per cycle. Results sit in an output register,
//   so a request is taken while the previous response waits. If the receiver stalls
//   and the register is still full, the lookup holds until it drains.
//   After reset the whole state memory is swept, one set at a time, with req.ready low;
//   configuration returns to 1 (hit latency) and 100 (miss penalty), totals to zero.
module set_assoc_cache_tag_lru_timing_top #(
    parameter int SET_COUNT  = 64,
    parameter int WAY_COUNT  = 4,
    parameter int LINE_OFS_W = 6,
    parameter int ADDR_BITS  = 32
) (
    input  logic  clk,
    input  logic  rst_n,
    sacache_req_if.sink   req,
    sacache_rsp_if.source rsp,
    sacache_cfg_if.sink   cfg
);
    import sacache_pkg::*;

    localparam int IDX_W    = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 0;
    localparam int SET_W    = (IDX_W > 0) ? IDX_W : 1;
    localparam int EFF_A    = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam int TAG_RAW  = EFF_A - LINE_OFS_W - IDX_W;
    localparam int TAG_W    = (TAG_RAW > 0) ? TAG_RAW : 1;
    localparam int AGE_W    = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
    localparam int META_W   = WAY_COUNT * (2 + AGE_W);
    localparam logic [ADDR_W-1:0] ADDR_MASK =
        (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} : ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);
    localparam logic [ADDR_W-1:0] SET_MASK  = ADDR_W'(SET_COUNT - 1);
    localparam logic [SET_W-1:0]  LAST_SET  = SET_W'(SET_COUNT - 1);

    // Control and configuration state.
    state_t                 state_reg, state_next;
    logic [SET_W-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [HIT_LAT_W-1:0]   hit_lat_reg;
    logic [MISS_PEN_W-1:0]  miss_pen_reg;
    logic [CNT_W-1:0]       access_count_reg, access_count_next;
    logic [CNT_W-1:0]       hit_count_reg, hit_count_next;

    // Captured request.
    op_t                    op_reg;
    logic [SET_W-1:0]       set_reg;
    logic [TAG_W-1:0]       tag_reg;

    // Memories and their registered read data.
    logic [WAY_COUNT*TAG_W-1:0] tag_mem [SET_COUNT];
    logic [META_W-1:0]          meta_mem [SET_COUNT];
    logic [WAY_COUNT*TAG_W-1:0] tag_rd_reg;
    logic [META_W-1:0]          meta_rd_reg;

    // Output register.
    logic                   rsp_valid_reg, rsp_valid_next;
    logic                   hit_reg;
    logic                   dirty_evict_reg;
    logic [LAT_W-1:0]       latency_reg;
    logic [CNT_W-1:0]       total_accesses_reg;
    logic [CNT_W-1:0]       total_hits_reg;

    // Combinational control.
    logic                   accept;
    logic                   out_free;
    logic                   load_rsp;
    logic                   is_access;
    logic                   tag_wr_en;
    logic                   meta_wr_en;
    logic [SET_W-1:0]       meta_wr_set;
    logic [META_W-1:0]      meta_wr_data;
    logic [ADDR_W-1:0]      addr_masked;
    logic [SET_W-1:0]       req_set;
    logic [TAG_W-1:0]       req_tag;
    logic [LAT_W-1:0]       miss_latency;

    // Lookup results.
    lookup_status_t             status;
    logic [WAY_COUNT*TAG_W-1:0] tag_row_new;
    logic [WAY_COUNT-1:0]       valid_row_new;
    logic [WAY_COUNT-1:0]       dirty_row_new;
    logic [WAY_COUNT*AGE_W-1:0] age_row_new;

    // Split the address into set index and tag.
    assign addr_masked = req.addr & ADDR_MASK;
    assign req_set     = SET_W'((addr_masked >> LINE_OFS_W) & SET_MASK);
    assign req_tag     = TAG_W'(addr_masked >> (LINE_OFS_W + IDX_W));

    // Handshakes.
    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign cfg.ready = 1'b1;
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign is_access = (op_reg == OP_READ) || (op_reg == OP_WRITE);

    // Set lookup on the row registered at acceptance.
    sacache_lookup #(
        .WAY_COUNT (WAY_COUNT),
        .TAG_W     (TAG_W),
        .AGE_W     (AGE_W)
    ) u_lookup (
        .tag_row       (tag_rd_reg),
        .valid_row     (meta_rd_reg[WAY_COUNT-1:0]),
        .dirty_row     (meta_rd_reg[2*WAY_COUNT-1:WAY_COUNT]),
        .age_row       (meta_rd_reg[META_W-1:2*WAY_COUNT]),
        .tag           (tag_reg),
        .is_write      (op_reg == OP_WRITE),
        .status        (status),
        .tag_row_new   (tag_row_new),
        .valid_row_new (valid_row_new),
        .dirty_row_new (dirty_row_new),
        .age_row_new   (age_row_new)
    );

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == LAST_SET)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (out_free)
                begin
                    state_next = (op_reg == OP_INVAL) ? ST_CLEAR : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output logic of the sequencer: memory writes and response loading.
    always_comb
    begin
        load_rsp     = 1'b0;
        tag_wr_en    = 1'b0;
        meta_wr_en   = 1'b0;
        meta_wr_set  = set_reg;
        meta_wr_data = {age_row_new, dirty_row_new, valid_row_new};
        unique case (state_reg)
            ST_CLEAR:
            begin
                meta_wr_en   = 1'b1;
                meta_wr_set  = clr_cnt_reg;
                meta_wr_data = '0;
            end
            ST_IDLE:
            begin
                load_rsp = 1'b0;
            end
            ST_LOOKUP:
            begin
                load_rsp   = out_free;
                tag_wr_en  = out_free && is_access;
                meta_wr_en = out_free && is_access;
            end
            default:
            begin
                load_rsp = 1'b0;
            end
        endcase
    end

    // Clearing sweep counter and running totals.
    always_comb
    begin
        clr_cnt_next      = (state_reg == ST_CLEAR) ? clr_cnt_reg + SET_W'(1) : '0;
        access_count_next = access_count_reg;
        hit_count_next    = hit_count_reg;
        if (load_rsp && is_access)
        begin
            access_count_next = access_count_reg + CNT_W'(1);
            if (status.hit)
            begin
                hit_count_next = hit_count_reg + CNT_W'(1);
            end
        end
    end

    // Miss latency, with half the penalty again for a dirty eviction.
    assign miss_latency = LAT_W'(miss_pen_reg) +
        (status.dirty_evict ? LAT_W'(miss_pen_reg / HALF_DIVISOR) : LAT_W'(0));

    // Response valid: set on load, cleared once taken.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (load_rsp)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_cnt_reg      <= '0;
            access_count_reg <= '0;
            hit_count_reg    <= '0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_cnt_reg      <= clr_cnt_next;
            access_count_reg <= access_count_next;
            hit_count_reg    <= hit_count_next;
            rsp_valid_reg    <= rsp_valid_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_lat_reg  <= HIT_LAT_RST;
            miss_pen_reg <= MISS_PEN_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_HIT_LAT:  hit_lat_reg  <= cfg.data[HIT_LAT_W-1:0];
                CFG_MISS_PEN: miss_pen_reg <= cfg.data[MISS_PEN_W-1:0];
                default:      ;
            endcase
        end
    end

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= req.op;
            set_reg <= req_set;
            tag_reg <= req_tag;
        end
    end

    // Response payload register.
    always_ff @(posedge clk)
    begin
        if (load_rsp)
        begin
            hit_reg            <= is_access && status.hit;
            dirty_evict_reg    <= is_access && status.dirty_evict;
            total_accesses_reg <= access_count_next;
            total_hits_reg     <= hit_count_next;
            if (!is_access)
            begin
                latency_reg <= '0;
            end
            else if (status.hit)
            begin
                latency_reg <= LAT_W'(hit_lat_reg);
            end
            else
            begin
                latency_reg <= miss_latency;
            end
        end
    end

    // Tag memory: read at acceptance, written back after the lookup.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tag_rd_reg <= tag_mem[req_set];
        end
        if (tag_wr_en)
        begin
            tag_mem[set_reg] <= tag_row_new;
        end
    end

    // State memory (valid, dirty, age): read at acceptance, written back or cleared.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            meta_rd_reg <= meta_mem[req_set];
        end
        if (meta_wr_en)
        begin
            meta_mem[meta_wr_set] <= meta_wr_data;
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.hit            = hit_reg;
    assign rsp.dirty_evict    = dirty_evict_reg;
    assign rsp.latency        = latency_reg;
    assign rsp.total_accesses = total_accesses_reg;
    assign rsp.total_hits     = total_hits_reg;

`ifndef NO_ASSERTIONS
    // An accepted request is looked up in the very next cycle.
    a_accept_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_LOOKUP))
        else $error("accepted request did not enter lookup");

    // A new response only appears after a lookup cycle.
    a_rsp_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (load_rsp) |-> (state_reg == ST_LOOKUP))
        else $error("response loaded outside lookup");

    // The hit total only moves together with the access total.
    a_hits_with_access: assert property (@(posedge clk) disable iff (!rst_n)
        (hit_count_reg != $past(hit_count_reg)) |->
            (access_count_reg != $past(access_count_reg)))
        else $error("hit counted without an access");

    // A dirty eviction is always a miss.
    a_evict_is_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && dirty_evict_reg) |-> !hit_reg)
        else $error("dirty eviction reported on a hit");

    // The lookup never writes the tag memory back while the response register is full and not being taken.
    a_no_write_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        tag_wr_en |-> (!rsp_valid_reg || rsp.ready))
        else $error("set written back while response stalled");
`endif

endmodule
